/* rtl/last_local_max_3x3_macros.svh */
// Assertion macros shared by the local maximum detector.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LAST_LOCAL_MAX_3X3_MACROS_SVH
`define LAST_LOCAL_MAX_3X3_MACROS_SVH
`ifndef SYNTHESIS
`define LMX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LMX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LMX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define LMX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/lmx_pkg.sv */
// Shared constants and types of the 3x3 local maximum detector.
// No dependencies; used by the interfaces and by all modules but the line buffer memory.
package lmx_pkg;

  localparam int VALUE_W    = 16;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 11;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_ROWS   = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

  typedef struct packed {
    logic             valid;
    logic             wr_en;
    logic             cen_ok;
    logic             a_zero;
    logic             b_zero;
    logic             last_col;
    logic             frame_end;
    logic [ROW_W-1:0] cen_row;
  } lmx_item_t;

endpackage

/* rtl/lmx_in_if.sv */
// Input channel of the local maximum detector: one grid value per request.
// Depends on lmx_pkg.
interface lmx_in_if;
  import lmx_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

/* rtl/lmx_out_if.sv */
// Result channel of the local maximum detector: one peak report per frame.
// Depends on lmx_pkg.
interface lmx_out_if;
  import lmx_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] peak_value;
  logic [ROW_W-1:0]   peak_row;
  logic [COL_W-1:0]   peak_col;

  modport source (output valid, output peak_value, output peak_row, output peak_col,
                  input ready);
  modport sink (input valid, input peak_value, input peak_row, input peak_col,
                output ready);
endinterface

/* rtl/lmx_line_mem.sv */
// Line buffer memory: one write port, one read port, registered read data.
// No dependencies.
module lmx_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/lmx_ctrl.sv */
// Frame sequencer: configuration, raster position, bottom-row flush and result hand-off.
// Depends on lmx_pkg and the assertion macros.
`include "last_local_max_3x3_macros.svh"
module lmx_ctrl #(
  parameter int MAX_COLS = 1024,
  parameter int VB = 16,
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lmx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmx_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [VB-1:0]                 in_value,
  input  logic                          frame_done,
  input  logic                          out_free,
  output logic                          emit,
  output logic                          clear_best,
  output lmx_pkg::lmx_item_t            issue,
  output logic [CW-1:0]                 issue_col,
  output logic [VB-1:0]                 issue_value
);
  import lmx_pkg::*;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [ROWS_CFG_W-1:0] grid_rows_r, grid_rows_nxt;
  logic [COLS_CFG_W-1:0] grid_cols_r, grid_cols_nxt;
  logic [ROW_W-1:0]      rows_m1;
  logic [CW-1:0]         cols_m1;
  logic                  accept;
  logic                  flush_step;
  logic                  last_col;

  always_comb begin
    if (grid_rows_r == '0) begin
      rows_m1 = '0;
    end else if (grid_rows_r > ROWS_CFG_W'(MAX_ROWS)) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(grid_rows_r - 1'b1);
    end
    if (grid_cols_r == '0) begin
      cols_m1 = '0;
    end else if (32'(grid_cols_r) > MAX_COLS) begin
      cols_m1 = CW'(MAX_COLS - 1);
    end else begin
      cols_m1 = CW'(grid_cols_r - 1'b1);
    end
  end

  assign in_ready   = (state_r == ST_RUN);
  assign accept     = in_valid && in_ready;
  assign flush_step = (state_r == ST_FLUSH);
  assign last_col   = (col_r == cols_m1);
  assign emit       = (state_r == ST_EMIT) && out_free;
  assign clear_best = emit || cfg_we;

  always_comb begin
    issue.valid     = accept || flush_step;
    issue.wr_en     = accept;
    issue.cen_ok    = flush_step || (row_r != '0);
    issue.a_zero    = accept && (row_r == '0);
    issue.b_zero    = flush_step ? (rows_m1 == '0) : (row_r <= ROW_W'(1));
    issue.last_col  = last_col;
    issue.frame_end = flush_step && last_col;
    issue.cen_row   = flush_step ? rows_m1 : ROW_W'(row_r - 1'b1);
    issue_col       = col_r;
    issue_value     = accept ? in_value : '0;
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows_nxt = ROWS_CFG_W'(cfg_data);
        REG_GRID_COLS: grid_cols_nxt = COLS_CFG_W'(cfg_data);
        default: ;
      endcase
      state_nxt = ST_RUN;
      row_nxt   = '0;
      col_nxt   = '0;
    end else begin
      unique case (state_r)
        ST_RUN: begin
          if (accept) begin
            if (last_col) begin
              col_nxt = '0;
              if (row_r == rows_m1) begin
                state_nxt = ST_FLUSH;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (last_col) begin
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = ST_DRAIN;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (frame_done) begin
            state_nxt = ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_nxt = ST_RUN;
          end
        end
        default: state_nxt = ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      row_r       <= '0;
      col_r       <= '0;
      grid_rows_r <= ROWS_CFG_W'(1);
      grid_cols_r <= COLS_CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
    end
  end

  `LMX_ASSERT_NOW(a_row_in_grid, clk, rst_n, 1'b1, row_r <= rows_m1, "Row counter left the grid.")
  `LMX_ASSERT_NOW(a_flush_col, clk, rst_n, state_r == ST_FLUSH, col_r <= cols_m1, "Flush column out of range.")
  `LMX_ASSERT_NEXT(a_flush_end, clk, rst_n, flush_step && last_col && !cfg_we, state_r == ST_DRAIN, "Flush did not end in drain.")
  `LMX_ASSERT_NEXT(a_emit_run, clk, rst_n, emit, state_r == ST_RUN, "Emit did not return to run.")

endmodule

/* rtl/lmx_peak.sv */
// Window stage: merges line buffer data, shifts the 3x3 window and tracks the last peak.
// Depends on lmx_pkg.
module lmx_peak #(
  parameter int VB = 16,
  parameter int CW = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lmx_pkg::lmx_item_t        issue,
  input  logic [CW-1:0]             issue_col,
  input  logic [VB-1:0]             issue_value,
  input  logic [2*VB-1:0]           rd_data,
  input  logic                      clear_best,
  output logic                      wr_en,
  output logic [CW-1:0]             wr_addr,
  output logic [2*VB-1:0]           wr_data,
  output logic [VB-1:0]             best_value,
  output logic [lmx_pkg::ROW_W-1:0] best_row,
  output logic [CW-1:0]             best_col,
  output logic                      frame_done
);
  import lmx_pkg::*;

  lmx_item_t        s1_r, s2_r;
  logic [CW-1:0]    s1_col_r, s2_col_r;
  logic [VB-1:0]    s1_val_r;
  logic             fwd_r;
  logic [2*VB-1:0]  fwd_data_r;
  logic [2*VB-1:0]  line;
  logic [VB-1:0]    up1, up2;
  logic [VB-1:0]    win_top_r [3];
  logic [VB-1:0]    win_mid_r [3];
  logic [VB-1:0]    win_bot_r [3];
  logic             peak_a, peak_b;
  logic [VB-1:0]    best_value_r;
  logic [ROW_W-1:0] best_row_r;
  logic [CW-1:0]    best_col_r;
  logic             frame_done_r;

  assign line    = fwd_r ? fwd_data_r : rd_data;
  assign up1     = s1_r.a_zero ? '0 : line[2*VB-1:VB];
  assign up2     = s1_r.b_zero ? '0 : line[VB-1:0];
  assign wr_en   = s1_r.valid && s1_r.wr_en;
  assign wr_addr = s1_col_r;
  assign wr_data = {s1_val_r, up1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r  <= '0;
      s2_r  <= '0;
      fwd_r <= 1'b0;
    end else begin
      s1_r  <= issue;
      s2_r  <= s1_r;
      fwd_r <= issue.valid && wr_en && (issue_col == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r   <= issue_col;
    s1_val_r   <= issue_value;
    s2_col_r   <= s1_col_r;
    fwd_data_r <= wr_data;
    if (s1_r.valid) begin
      if (s1_col_r == '0) begin
        win_top_r[0] <= '0;
        win_mid_r[0] <= '0;
        win_bot_r[0] <= '0;
        win_top_r[1] <= '0;
        win_mid_r[1] <= '0;
        win_bot_r[1] <= '0;
      end else begin
        win_top_r[0] <= win_top_r[1];
        win_mid_r[0] <= win_mid_r[1];
        win_bot_r[0] <= win_bot_r[1];
        win_top_r[1] <= win_top_r[2];
        win_mid_r[1] <= win_mid_r[2];
        win_bot_r[1] <= win_bot_r[2];
      end
      win_top_r[2] <= up2;
      win_mid_r[2] <= up1;
      win_bot_r[2] <= s1_val_r;
    end
  end

  // The center column and, at the end of a row, the rightmost column with zero padding.
  assign peak_a = s2_r.valid && s2_r.cen_ok && (s2_col_r != '0) &&
                  (win_mid_r[1] > win_top_r[0]) && (win_mid_r[1] > win_top_r[1]) &&
                  (win_mid_r[1] > win_top_r[2]) && (win_mid_r[1] > win_mid_r[0]) &&
                  (win_mid_r[1] > win_mid_r[2]) && (win_mid_r[1] > win_bot_r[0]) &&
                  (win_mid_r[1] > win_bot_r[1]) && (win_mid_r[1] > win_bot_r[2]);
  assign peak_b = s2_r.valid && s2_r.cen_ok && s2_r.last_col && (win_mid_r[2] != '0) &&
                  (win_mid_r[2] > win_top_r[1]) && (win_mid_r[2] > win_top_r[2]) &&
                  (win_mid_r[2] > win_mid_r[1]) && (win_mid_r[2] > win_bot_r[1]) &&
                  (win_mid_r[2] > win_bot_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_value_r <= '0;
      best_row_r   <= '0;
      best_col_r   <= '0;
      frame_done_r <= 1'b0;
    end else begin
      frame_done_r <= s2_r.valid && s2_r.frame_end;
      if (clear_best) begin
        best_value_r <= '0;
        best_row_r   <= '0;
        best_col_r   <= '0;
      end else if (peak_b) begin
        best_value_r <= win_mid_r[2];
        best_row_r   <= s2_r.cen_row;
        best_col_r   <= s2_col_r;
      end else if (peak_a) begin
        best_value_r <= win_mid_r[1];
        best_row_r   <= s2_r.cen_row;
        best_col_r   <= s2_col_r - 1'b1;
      end
    end
  end

  assign best_value = best_value_r;
  assign best_row   = best_row_r;
  assign best_col   = best_col_r;
  assign frame_done = frame_done_r;

endmodule

/* rtl/last_local_max_3x3.sv */
// Last strict 3x3 local maximum of a raster-order grid.
// Feed the grid values in raster order on in_ch; grid_rows and grid_cols are set on the
// cfg port (index 0 and 1), which restarts the frame and clears the remembered peak.
// Each value is compared with its eight neighbors, and positions outside the grid
// count as zero. After the last value of a frame, one result with the value, row and
// column of the last peak in raster order appears on out_ch (all zero if none).
// Throughput is one value per cycle within a frame. After the last value, the bottom
// row is flushed through the window, one step per column, and in_ch is held off until
// the result has been loaded into the output register.
// The state lives in one line buffer memory of MAX_COLS words, each holding the two
// rows above the current one, read and rewritten once per value.
// After reset the grid is 1 by 1 and no frame is in progress; the memory needs no
// clearing because rows above the top of the grid are masked to zero.
// The result is held in an output register until taken; a new frame can be fed while it
// waits, but the next result is held back, and in_ch with it, until the previous one
// has been taken.
module last_local_max_3x3 #(
  parameter int MAX_COLS   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lmx_in_if.sink                         in_ch,
  lmx_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lmx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lmx_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  lmx_item_t           issue;
  logic [CW-1:0]       issue_col;
  logic [VALUE_BITS-1:0] issue_value;
  logic                frame_done;
  logic                out_free;
  logic                emit;
  logic                clear_best;
  logic [2*VALUE_BITS-1:0] rd_data;
  logic                wr_en;
  logic [CW-1:0]       wr_addr;
  logic [2*VALUE_BITS-1:0] wr_data;
  logic [VALUE_BITS-1:0] best_value;
  logic [ROW_W-1:0]    best_row;
  logic [CW-1:0]       best_col;
  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [COL_W-1:0]    out_col_r;

  assign out_free = !out_valid_r || out_ch.ready;

  lmx_ctrl #(
    .MAX_COLS (MAX_COLS),
    .VB       (VALUE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_value    (VALUE_BITS'(in_ch.cell_value)),
    .frame_done  (frame_done),
    .out_free    (out_free),
    .emit        (emit),
    .clear_best  (clear_best),
    .issue       (issue),
    .issue_col   (issue_col),
    .issue_value (issue_value)
  );

  lmx_line_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (2 * VALUE_BITS)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (issue.valid),
    .rd_addr (issue_col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lmx_peak #(
    .VB (VALUE_BITS),
    .CW (CW)
  ) u_peak (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue       (issue),
    .issue_col   (issue_col),
    .issue_value (issue_value),
    .rd_data     (rd_data),
    .clear_best  (clear_best),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .best_value  (best_value),
    .best_row    (best_row),
    .best_col    (best_col),
    .frame_done  (frame_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= VALUE_W'(best_value);
      out_row_r   <= best_row;
      out_col_r   <= COL_W'(best_col);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.peak_value = out_value_r;
  assign out_ch.peak_row   = out_row_r;
  assign out_ch.peak_col   = out_col_r;

endmodule
